[hw/rtl/pfsmr_pkg.sv]
// Shared constants and types for the programmable FSM with reachability.
package pfsmr_pkg;

  localparam int NUM_STATES_DEF = 8;
  localparam int RESET_PRESENT_DEF = 5;

  localparam logic [1:0] OP_STEP   = 2'd0;
  localparam logic [1:0] OP_REWIRE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  // Reset edge table for the eight named states, entry 2*s+b.
  localparam logic [2:0] RESET_EDGES [16] = '{
    3'd1, 3'd2, 3'd4, 3'd5, 3'd0, 3'd4, 3'd7, 3'd6,
    3'd3, 3'd4, 3'd6, 3'd0, 3'd2, 3'd7, 3'd5, 3'd1
  };

  typedef struct packed {
    logic busy;
    logic done;
  } reach_stat_t;

endpackage

[hw/rtl/programmable_fsm_with_reachability.sv]
// Top level: command sequencer, edge table RAM, reachability engine and result register.
//
//  channel | signals                                          | transaction
//  --------+--------------------------------------------------+--------------------------
//  in      | in_valid, in_ready, opcode, edge_bit, target_index | one command
//  out     | out_valid, out_ready, present_state, masks, flags  | one result per command
//
// A command's result waits for a reachability closure from the new present state; the
// single edge RAM port, two reads per visited state, paces the closure. A step command
// first reads its edge from the table to find the new present state.
// After reset all 2*NUM_STATES edge table entries are loaded with in_ready low.
// A finished result waits in the output register; the next command may be taken meanwhile.
module programmable_fsm_with_reachability #(
  parameter int NUM_STATES = pfsmr_pkg::NUM_STATES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic       edge_bit,
  input  logic [2:0] target_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] present_state,
  output logic [7:0] unreachable_mask,
  output logic [7:0] deleted_mask,
  output logic [7:0] newly_deleted_mask,
  output logic       query_hit,
  output logic       rewire_error
);

  localparam int SW = $clog2(NUM_STATES);
  localparam int AW = SW + 1;
  localparam int DEPTH = 2 * NUM_STATES;
  localparam int RESET_PRESENT = pfsmr_pkg::RESET_PRESENT_DEF % NUM_STATES;

  typedef enum logic [5:0] {
    T_INIT  = 6'b000001,
    T_IDLE  = 6'b000010,
    T_EXEC  = 6'b000100,
    T_STEP  = 6'b001000,
    T_WAITR = 6'b010000,
    T_FIN   = 6'b100000
  } tstate_t;

  tstate_t               state;
  logic [AW-1:0]         fill_addr;
  logic [SW-1:0]         present;
  logic [NUM_STATES-1:0] del;
  logic [1:0]            op;
  logic                  bit_sel;
  logic [2:0]            tgt;
  logic                  err;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [SW-1:0]         ram_wdata;
  logic [SW-1:0]         ram_rdata;
  logic [SW-1:0]         fill_value;

  logic                  reach_start;
  logic [SW-1:0]         reach_root;
  logic [AW-1:0]         reach_addr;
  logic [NUM_STATES-1:0] reach_mask;
  pfsmr_pkg::reach_stat_t reach_stat;

  logic [SW-1:0]         tgt_idx;
  logic                  tgt_in_range;
  logic                  rewire_ok;
  logic [NUM_STATES-1:0] unreach;
  logic [NUM_STATES-1:0] fresh;
  logic [NUM_STATES-1:0] del_new;
  logic                  hit;
  logic                  out_load;
  logic [NUM_STATES+7:0] unreach_ext;
  logic [NUM_STATES+7:0] del_ext;
  logic [NUM_STATES+7:0] fresh_ext;
  logic [SW+2:0]         present_ext;

  assign tgt_idx      = SW'(tgt);
  assign tgt_in_range = (7'(tgt) < 7'(NUM_STATES));
  assign rewire_ok    = tgt_in_range && !del[tgt_idx];

  // reset table value for the entry being loaded
  always_comb begin
    logic [AW+2:0] a_ext;
    logic [6:0]    rr;
    a_ext = (AW+3)'(fill_addr);
    rr    = 7'(pfsmr_pkg::RESET_EDGES[4'(fill_addr)]);
    for (int k = 0; k < 7; k++) begin
      if (rr >= 7'(NUM_STATES)) begin
        rr = rr - 7'(NUM_STATES);
      end
    end
    if ((a_ext >> 1) < (AW+3)'(8)) begin
      fill_value = SW'(rr);
    end else begin
      fill_value = fill_addr[AW-1:1];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = reach_addr;
    ram_wdata = tgt_idx;
    case (state)
      T_INIT: begin
        ram_we    = 1'b1;
        ram_addr  = fill_addr;
        ram_wdata = fill_value;
      end
      T_EXEC: begin
        ram_addr = {present, bit_sel};
        ram_we   = (op == pfsmr_pkg::OP_REWIRE) && rewire_ok;
      end
      default: ;
    endcase
  end

  assign reach_start = ((state == T_EXEC) && (op != pfsmr_pkg::OP_STEP)) || (state == T_STEP);
  assign reach_root  = (state == T_STEP) ? ram_rdata : present;

  pfsmr_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_edges (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pfsmr_reach #(
    .NUM_STATES (NUM_STATES)
  ) u_reach (
    .clk   (clk),
    .rst   (rst),
    .start (reach_start),
    .root  (reach_root),
    .rdata (ram_rdata),
    .addr  (reach_addr),
    .mask  (reach_mask),
    .stat  (reach_stat)
  );

  assign unreach = ~reach_mask;
  assign fresh   = (op == pfsmr_pkg::OP_DELETE) ? (unreach & ~del) : '0;
  assign del_new = del | fresh;
  assign hit     = (op == pfsmr_pkg::OP_QUERY) && tgt_in_range && unreach[tgt_idx] && del[tgt_idx];

  assign unreach_ext = (NUM_STATES+8)'(unreach);
  assign del_ext     = (NUM_STATES+8)'(del_new);
  assign fresh_ext   = (NUM_STATES+8)'(fresh);
  assign present_ext = (SW+3)'(present);

  assign in_ready = (state == T_IDLE);
  assign out_load = (state == T_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_INIT;
      fill_addr <= '0;
      present   <= SW'(RESET_PRESENT);
      del       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_INIT: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == AW'(DEPTH - 1)) begin
            state <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (in_valid) begin
            state <= T_EXEC;
          end
        end
        T_EXEC: begin
          if (op == pfsmr_pkg::OP_STEP) begin
            state <= T_STEP;
          end else begin
            state <= T_WAITR;
          end
        end
        T_STEP: begin
          present <= ram_rdata;
          state   <= T_WAITR;
        end
        T_WAITR: begin
          if (reach_stat.done) begin
            state <= T_FIN;
          end
        end
        T_FIN: begin
          if (out_load) begin
            del   <= del_new;
            state <= T_IDLE;
          end
        end
        default: state <= T_INIT;
      endcase
    end
  end

  // command fields and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op      <= opcode;
      bit_sel <= edge_bit;
      tgt     <= target_index;
    end
    if (state == T_EXEC) begin
      err <= (op == pfsmr_pkg::OP_REWIRE) && !rewire_ok;
    end
    if (out_load) begin
      present_state      <= present_ext[2:0];
      unreachable_mask   <= unreach_ext[7:0];
      deleted_mask       <= del_ext[7:0];
      newly_deleted_mask <= fresh_ext[7:0];
      query_hit          <= hit;
      rewire_error       <= err;
    end
  end

`ifndef SYNTHESIS
  a_del_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((del & $past(del)) == $past(del)))
    else $error("deleted marks cleared");

  a_present_reached: assert property (@(posedge clk) disable iff (rst)
    (state == T_FIN) |-> reach_mask[present])
    else $error("present state not in reach set");

  a_no_write_in_closure: assert property (@(posedge clk) disable iff (rst)
    reach_stat.busy |-> !ram_we)
    else $error("edge table written during closure");

  a_fresh_subset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((newly_deleted_mask & ~deleted_mask) == 8'd0))
    else $error("newly deleted state not marked deleted");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == T_EXEC))
    else $error("accepted command not executed");
`endif

endmodule

[hw/rtl/pfsmr_ram.sv]
// Generic single-port RAM with registered read.
module pfsmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/pfsmr_reach.sv]
// Reachability closure engine: expands one reached state at a time over the edge RAM port.
module pfsmr_reach #(
  parameter int NUM_STATES = pfsmr_pkg::NUM_STATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [$clog2(NUM_STATES)-1:0]   root,
  input  logic [$clog2(NUM_STATES)-1:0]   rdata,
  output logic [$clog2(NUM_STATES):0]     addr,
  output logic [NUM_STATES-1:0]           mask,
  output pfsmr_pkg::reach_stat_t          stat
);

  localparam int SW = $clog2(NUM_STATES);
  localparam logic [NUM_STATES-1:0] ONE_HOT0 = {{(NUM_STATES-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    R_IDLE   = 4'b0001,
    R_ISSUE0 = 4'b0010,
    R_ISSUE1 = 4'b0100,
    R_MERGE1 = 4'b1000
  } rstate_t;

  rstate_t               state;
  logic [NUM_STATES-1:0] reach;
  logic [NUM_STATES-1:0] expanded;
  logic [NUM_STATES-1:0] pending;
  logic [SW-1:0]         cur;
  logic [SW-1:0]         pick;

  assign pending = reach & ~expanded;
  assign mask    = reach;

  always_comb begin
    pick = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = SW'(i);
      end
    end
  end

  always_comb begin
    case (state)
      R_ISSUE0: addr = {pick, 1'b0};
      R_ISSUE1: addr = {cur, 1'b1};
      default:  addr = {cur, 1'b1};
    endcase
  end

  assign stat.busy = (state != R_IDLE);
  assign stat.done = (state == R_ISSUE0) && (pending == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= R_IDLE;
      reach    <= '0;
      expanded <= '0;
      cur      <= '0;
    end else begin
      case (state)
        R_IDLE: begin
          if (start) begin
            reach    <= ONE_HOT0 << root;
            expanded <= '0;
            state    <= R_ISSUE0;
          end
        end
        R_ISSUE0: begin
          if (pending == '0) begin
            state <= R_IDLE;
          end else begin
            expanded <= expanded | (ONE_HOT0 << pick);
            cur      <= pick;
            state    <= R_ISSUE1;
          end
        end
        R_ISSUE1: begin
          // edge 0 of cur arrives
          reach <= reach | (ONE_HOT0 << rdata);
          state <= R_MERGE1;
        end
        R_MERGE1: begin
          reach <= reach | (ONE_HOT0 << rdata);
          state <= R_ISSUE0;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule
